[hw/rtl/trb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trb_pkg: shared types and constants of the timestamp reorder buffer
// Ring geometry, entry layout, outcome codes and time constants.
// ----------------------------------------------------------------------------
package trb_pkg;

    localparam int RING_DEPTH = 256;
    localparam int IDX_W      = $clog2(RING_DEPTH);

    localparam int SEC_W      = 32;
    localparam int NSEC_W     = 30;
    localparam int STAMP_W    = SEC_W + NSEC_W;
    localparam int HANDLE_W   = 16;
    localparam int WIN_W      = 31;
    localparam int OUTCOME_W  = 3;
    localparam int OCC_W      = 8;

    localparam int MS_PER_S   = 1000;
    localparam int NS_PER_MS  = 1000000;
    localparam int NS_PER_S   = 1000000000;
    localparam int WIN_DEFAULT = 1000;

    // quotient bits of ns / NS_PER_MS for a 30-bit magnitude
    localparam int Q_W        = 11;

    // ns / NS_PER_MS as (ns * NS_MS_RCP) >> RCP_SHIFT, exact for any 30-bit ns;
    // NS_MS_RCP = ceil(2^50 / NS_PER_MS)
    localparam int RCP_W      = 31;
    localparam int RCP_SHIFT  = 50;
    localparam logic [RCP_W-1:0] NS_MS_RCP = 31'd1125899907;

    localparam logic MODE_PUSH    = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    localparam logic [OUTCOME_W-1:0] OUT_NONE     = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_RELEASED = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_INSERTED = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_DROPPED  = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_FILTERED = 3'd4;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic [SEC_W-1:0]    seconds;
        logic [NSEC_W-1:0]   nanoseconds;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic idx_t ring_next(input idx_t i);
        return (i == IDX_W'(RING_DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
    endfunction

    function automatic idx_t ring_prev(input idx_t i);
        return (i == '0) ? IDX_W'(RING_DEPTH - 1) : idx_t'(i - 1'b1);
    endfunction

endpackage

[hw/rtl/trb_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trb_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module trb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/timestamp_reorder_buffer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_reorder_buffer_core: sorted ring of timestamped handles
// Pushes insert entries in timestamp order; releases hand out the oldest
// entry once it is older than the configured window.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one item per request. s_mode = push (insert entry)
//   or release (test the oldest entry against s_now_*). Result channel m_*:
//   exactly one item per input item, in order.
//   cfg_wr_en/cfg_wr_data load window_ms (0 acts as 1000 ms); write it only
//   while the block is idle.
//   One item at a time: s_ready is high only while the sequencer is idle.
//   A filtered push or a release on an empty ring goes straight to the
//   result. A push to a full ring first drops the oldest entry in DROP.
//   The push cost is set by the single RAM port pair: each shifted slot is
//   read in SHIFT, then compared and written in CMP. A release forms the
//   time differences in REL, ms = s*1000 + ns/1e6 (reciprocal multiply)
//   in DIV and does the window compare in TIME.
//   The result holds on m_* until m_ready; a stalled receiver stalls the
//   block. Reset empties the ring (head = tail) and sets the window to
//   1000 ms; RAM contents are not cleared, no clearing pass is needed.
// ----------------------------------------------------------------------------
module timestamp_reorder_buffer_core (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wr_en,
    input  logic [trb_pkg::WIN_W-1:0]       cfg_wr_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_mode,
    input  logic                            s_passes_filter,
    input  logic [trb_pkg::SEC_W-1:0]       s_entry_seconds,
    input  logic [trb_pkg::NSEC_W-1:0]      s_entry_nanoseconds,
    input  logic [trb_pkg::HANDLE_W-1:0]    s_entry_handle,
    input  logic [trb_pkg::SEC_W-1:0]       s_now_seconds,
    input  logic [trb_pkg::NSEC_W-1:0]      s_now_nanoseconds,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [trb_pkg::OUTCOME_W-1:0]   m_outcome,
    output logic [trb_pkg::SEC_W-1:0]       m_out_seconds,
    output logic [trb_pkg::NSEC_W-1:0]      m_out_nanoseconds,
    output logic [trb_pkg::HANDLE_W-1:0]    m_out_handle,
    output logic [trb_pkg::OCC_W-1:0]       m_occupancy
);

    import trb_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DROP  = 3'd1;  // oldest entry arrives, drop it
    localparam logic [2:0] ST_SHIFT = 3'd2;  // stop at head or read slot below
    localparam logic [2:0] ST_CMP   = 3'd3;  // compare slot below, write one
    localparam logic [2:0] ST_REL   = 3'd4;  // oldest entry arrives, diff times
    localparam logic [2:0] ST_DIV   = 3'd5;  // s * 1000 and ns / 1e6
    localparam logic [2:0] ST_TIME  = 3'd6;  // elapsed ms vs window
    localparam logic [2:0] ST_OUT   = 3'd7;  // result held on m_*

    localparam int SD_W = SEC_W + 2;         // signed seconds difference
    localparam int ND_W = NSEC_W + 2;        // signed nanoseconds difference
    localparam int EL_W = SD_W + 12;         // signed elapsed milliseconds

    // control
    logic [2:0]             state_reg, state_next;
    idx_t                   head_reg, head_next;
    idx_t                   tail_reg, tail_next;
    idx_t                   idx_reg, idx_next;
    logic [WIN_W-1:0]       win_reg, win_next;

    // datapath
    logic [STAMP_W-1:0]     key_reg, key_next;      // entry stamp or "now"
    logic [HANDLE_W-1:0]    handle_reg, handle_next;
    logic [OUTCOME_W-1:0]   outcome_reg, outcome_next;
    entry_t                 out_reg, out_next;
    logic signed [SD_W-1:0] sdiff_reg, sdiff_next;
    logic [NSEC_W-1:0]      rem_reg, rem_next;
    logic                   neg_reg, neg_next;
    logic [Q_W-1:0]         q_reg, q_next;
    logic signed [EL_W-1:0] prod_reg, prod_next;

    // RAM
    logic                   ram_we;
    idx_t                   ram_waddr;
    idx_t                   ram_raddr;
    entry_t                 ram_wdata;
    entry_t                 ram_rdata;

    logic [IDX_W:0]         held;

    trb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // head read is issued in IDLE; slot below idx is read in SHIFT
    assign ram_raddr = (state_reg == ST_SHIFT) ? ring_prev(idx_reg) : head_reg;

    always_comb begin
        logic signed [ND_W-1:0]  nsd;
        logic signed [ND_W-1:0]  nsmag;
        logic                    borrow;
        logic [NSEC_W+RCP_W-1:0] qprod;
        logic signed [EL_W-1:0]  sd;
        logic signed [EL_W-1:0]  qs;
        logic signed [EL_W-1:0]  elapsed;
        logic signed [EL_W-1:0]  win_s;

        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        idx_next     = idx_reg;
        win_next     = win_reg;
        key_next     = key_reg;
        handle_next  = handle_reg;
        outcome_next = outcome_reg;
        out_next     = out_reg;
        sdiff_next   = sdiff_reg;
        rem_next     = rem_reg;
        neg_next     = neg_reg;
        q_next       = q_reg;
        prod_next    = prod_reg;

        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = '{seconds: key_reg[STAMP_W-1:NSEC_W],
                      nanoseconds: key_reg[NSEC_W-1:0],
                      handle: handle_reg};

        nsd     = '0;
        nsmag   = '0;
        borrow  = 1'b0;
        qprod   = '0;
        sd      = EL_W'(sdiff_reg);
        qs      = neg_reg ? -EL_W'(q_reg) : EL_W'(q_reg);
        elapsed = prod_reg + qs;
        win_s   = (win_reg == '0) ? EL_W'(WIN_DEFAULT) : EL_W'(win_reg);

        if (cfg_wr_en) begin
            win_next = cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    out_next    = '0;
                    handle_next = s_entry_handle;
                    if (s_mode == MODE_PUSH) begin
                        key_next = {s_entry_seconds, s_entry_nanoseconds};
                        if (!s_passes_filter) begin
                            outcome_next = OUT_FILTERED;
                            state_next   = ST_OUT;
                        end else if (ring_next(tail_reg) == head_reg) begin
                            state_next = ST_DROP;
                        end else begin
                            outcome_next = OUT_INSERTED;
                            idx_next     = tail_reg;
                            state_next   = ST_SHIFT;
                        end
                    end else begin
                        key_next = {s_now_seconds, s_now_nanoseconds};
                        if (head_reg == tail_reg) begin
                            outcome_next = OUT_NONE;
                            state_next   = ST_OUT;
                        end else begin
                            state_next = ST_REL;
                        end
                    end
                end
            end

            ST_DROP: begin
                out_next     = ram_rdata;
                outcome_next = OUT_DROPPED;
                head_next    = ring_next(head_reg);
                idx_next     = tail_reg;
                state_next   = ST_SHIFT;
            end

            ST_SHIFT: begin
                if (idx_reg == head_reg) begin
                    ram_we     = 1'b1;
                    tail_next  = ring_next(tail_reg);
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_CMP;
                end
            end

            ST_CMP: begin
                ram_we = 1'b1;
                if ({ram_rdata.seconds, ram_rdata.nanoseconds} < key_reg) begin
                    tail_next  = ring_next(tail_reg);
                    state_next = ST_OUT;
                end else begin
                    // equal stamps move up too: new entry lands before them
                    ram_wdata  = ram_rdata;
                    idx_next   = ring_prev(idx_reg);
                    state_next = ST_SHIFT;
                end
            end

            ST_REL: begin
                out_next = ram_rdata;
                nsd = $signed(ND_W'(key_reg[NSEC_W-1:0]))
                    - $signed(ND_W'(ram_rdata.nanoseconds));
                if (nsd < 0) begin
                    nsd    = nsd + ND_W'(NS_PER_S);
                    borrow = 1'b1;
                end
                // may still be negative for out-of-range nanoseconds
                nsmag      = (nsd < 0) ? -nsd : nsd;
                neg_next   = (nsd < 0);
                rem_next   = nsmag[NSEC_W-1:0];
                sdiff_next = $signed(SD_W'(key_reg[STAMP_W-1:NSEC_W]))
                           - $signed(SD_W'(ram_rdata.seconds))
                           - $signed(SD_W'(borrow));
                state_next = ST_DIV;
            end

            ST_DIV: begin
                // s * 1000 = s*1024 - s*16 - s*8
                prod_next  = (sd <<< 10) - (sd <<< 4) - (sd <<< 3);
                // |ns| / 1e6 by reciprocal multiply, truncating
                qprod      = (NSEC_W + RCP_W)'(rem_reg) * (NSEC_W + RCP_W)'(NS_MS_RCP);
                q_next     = qprod[RCP_SHIFT +: Q_W];
                state_next = ST_TIME;
            end

            ST_TIME: begin
                if (win_s < elapsed) begin
                    outcome_next = OUT_RELEASED;
                    head_next    = ring_next(head_reg);
                end else begin
                    outcome_next = OUT_NONE;
                    out_next     = '0;
                end
                state_next = ST_OUT;
            end

            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            idx_reg   <= '0;
            win_reg   <= WIN_W'(WIN_DEFAULT);
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            idx_reg   <= idx_next;
            win_reg   <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        handle_reg  <= handle_next;
        outcome_reg <= outcome_next;
        out_reg     <= out_next;
        sdiff_reg   <= sdiff_next;
        rem_reg     <= rem_next;
        neg_reg     <= neg_next;
        q_reg       <= q_next;
        prod_reg    <= prod_next;
    end

    // entries held; head and tail do not move while the result waits
    assign held = (tail_reg >= head_reg)
                ? ({1'b0, tail_reg} - {1'b0, head_reg})
                : ({1'b0, tail_reg} + (IDX_W + 1)'(RING_DEPTH) - {1'b0, head_reg});

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = (state_reg == ST_OUT);
    assign m_outcome         = outcome_reg;
    assign m_out_seconds     = out_reg.seconds;
    assign m_out_nanoseconds = out_reg.nanoseconds;
    assign m_out_handle      = out_reg.handle;
    assign m_occupancy       = OCC_W'(held);

endmodule
